>>> sv/snco_pkg.sv
`default_nettype none

package snco_pkg;

  // Fixed-point constants for building the quarter-wave table (Q2.30)
  localparam logic [63:0] Q30One   = 64'd1073741824;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // Flags that travel with an item from one pipeline stage to the next
  typedef struct packed {
    logic valid;
    logic last;
    logic neg;
  } snco_ctl_t;

  // sin(x) for x in [0, pi/2], Q2.30 in and out, odd polynomial of degree 15
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (x * x) >> 30;
    t  = Q30One;
    t  = Q30One - (((x2 * t) >> 30) / 64'd210);
    t  = Q30One - (((x2 * t) >> 30) / 64'd156);
    t  = Q30One - (((x2 * t) >> 30) / 64'd110);
    t  = Q30One - (((x2 * t) >> 30) / 64'd72);
    t  = Q30One - (((x2 * t) >> 30) / 64'd42);
    t  = Q30One - (((x2 * t) >> 30) / 64'd20);
    t  = Q30One - (((x2 * t) >> 30) / 64'd6);
    return (x * t) >> 30;
  endfunction

  // One quarter-wave entry, rounded to the given amplitude
  function automatic logic [63:0] quarter_wave_entry(input logic [63:0] i,
                                                     input int unsigned addr_bits,
                                                     input logic [63:0] amplitude);
    logic [63:0] x;
    logic [63:0] s;
    x = (HalfPiQ30 * i) >> addr_bits;
    s = sine_q30(x);
    return (s * amplitude + 64'd536870912) >> 30;
  endfunction

endpackage

`default_nettype wire

>>> sv/snco_lookup.sv
`default_nettype none

module snco_lookup #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned OUT_BITS        = 16,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  snco_pkg::snco_ctl_t      up_ctl_i,
  input  wire  [PHASE_BITS-1:0]    phase_i,
  output logic                     up_ready_o,
  input  wire                      dn_ready_i,
  output snco_pkg::snco_ctl_t      dn_ctl_o,
  output logic [OUT_BITS-1:0]      lo_o,
  output logic [OUT_BITS-1:0]      hi_o,
  output logic [PHASE_BITS-TABLE_ADDR_BITS-2:0] frac_o
);

  localparam int unsigned IdxW     = TABLE_ADDR_BITS + 1;
  localparam int unsigned FracW    = PHASE_BITS - TABLE_ADDR_BITS - 1;
  localparam int unsigned TableLen = (1 << TABLE_ADDR_BITS) + 1;
  localparam logic [63:0] Amplitude = (64'd1 << (OUT_BITS - 1)) - 64'd1;
  localparam logic [IdxW-1:0] QuarterSize = IdxW'(1) << TABLE_ADDR_BITS;
  localparam logic [PHASE_BITS-2:0] Quarter = (PHASE_BITS-1)'(1) << (PHASE_BITS - 2);

  typedef logic [OUT_BITS-1:0] rom_t [TableLen];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < TableLen; i++) begin
      r[i] = OUT_BITS'(snco_pkg::quarter_wave_entry(64'(i), TABLE_ADDR_BITS, Amplitude));
    end
    return r;
  endfunction

  localparam rom_t QuarterWave = build_rom();

  logic [1:0]            quad;
  logic [PHASE_BITS-2:0] u_raw;
  logic [PHASE_BITS-2:0] u;
  logic [PHASE_BITS-1:0] u_ext;
  logic [IdxW-1:0]       idx_lo;
  logic [IdxW-1:0]       idx_hi;
  logic                  load;

  snco_pkg::snco_ctl_t   ctl_q;
  logic [OUT_BITS-1:0]   lo_q;
  logic [OUT_BITS-1:0]   hi_q;
  logic [FracW-1:0]      frac_q;

  // Mirror odd quadrants; one extra low bit keeps the fraction nonempty
  always_comb begin
    quad   = phase_i[PHASE_BITS-1 -: 2];
    u_raw  = {1'b0, phase_i[PHASE_BITS-3:0]};
    u      = quad[0] ? (Quarter - u_raw) : u_raw;
    u_ext  = {u, 1'b0};
    idx_lo = u_ext[PHASE_BITS-1:FracW];
    idx_hi = (idx_lo < QuarterSize) ? (idx_lo + IdxW'(1)) : idx_lo;
  end

  assign up_ready_o = !ctl_q.valid || dn_ready_i;
  assign load       = up_ready_o;

  // Hold the stage flags; drop valid once the request moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (load) begin
      ctl_q.valid <= up_ctl_i.valid;
      ctl_q.last  <= up_ctl_i.last;
      ctl_q.neg   <= quad[1];
    end
  end

  // Registered table read at both interpolation points
  always_ff @(posedge clk_i) begin
    if (load && up_ctl_i.valid) begin
      lo_q   <= QuarterWave[idx_lo];
      hi_q   <= QuarterWave[idx_hi];
      frac_q <= u_ext[FracW-1:0];
    end
  end

  assign dn_ctl_o = ctl_q;
  assign lo_o     = lo_q;
  assign hi_o     = hi_q;
  assign frac_o   = frac_q;

endmodule

`default_nettype wire

>>> sv/snco_interp.sv
`default_nettype none

module snco_interp #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned OUT_BITS        = 16,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  snco_pkg::snco_ctl_t      up_ctl_i,
  input  wire  [OUT_BITS-1:0]      lo_i,
  input  wire  [OUT_BITS-1:0]      hi_i,
  input  wire  [PHASE_BITS-TABLE_ADDR_BITS-2:0] frac_i,
  output logic                     up_ready_o,
  output logic                     valid_o,
  output logic                     last_o,
  input  wire                      ready_i,
  output logic [OUT_BITS-1:0]      sample_o
);

  localparam int unsigned FracW = PHASE_BITS - TABLE_ADDR_BITS - 1;
  localparam int unsigned PadW  = FracW + (FracW % 2);
  localparam int unsigned HalfW = PadW / 2;
  localparam int unsigned PpW   = OUT_BITS + HalfW;
  localparam int unsigned SumW  = OUT_BITS + PadW + 1;
  localparam logic [SumW-1:0] Half = SumW'(1) << (FracW - 1);

  logic [OUT_BITS-1:0] diff;
  logic [PadW-1:0]     frac_pad;
  logic                ready3;
  logic                ready4;

  snco_pkg::snco_ctl_t ctl3_q;
  logic [PpW-1:0]      pp_lo_q;
  logic [PpW-1:0]      pp_hi_q;
  logic [OUT_BITS-1:0] base_q;

  logic [SumW-1:0]     sum;
  logic [OUT_BITS-1:0] mag;
  logic [OUT_BITS-1:0] signed_mag;

  logic                valid4_q;
  logic                last4_q;
  logic [OUT_BITS-1:0] sample_q;

  assign ready4     = !valid4_q || ready_i;
  assign ready3     = !ctl3_q.valid || ready4;
  assign up_ready_o = ready3;

  // Split the slope product into two half-width partial products
  always_comb begin
    diff     = hi_i - lo_i;
    frac_pad = PadW'(frac_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else if (ready3) begin
      ctl3_q <= up_ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready3 && up_ctl_i.valid) begin
      pp_lo_q <= PpW'(diff) * PpW'(frac_pad[HalfW-1:0]);
      pp_hi_q <= PpW'(diff) * PpW'(frac_pad[PadW-1:HalfW]);
      base_q  <= lo_i;
    end
  end

  // Combine partials with rounding, add the base entry, apply the sign
  always_comb begin
    sum        = (SumW'(pp_hi_q) << HalfW) + SumW'(pp_lo_q) + Half;
    mag        = base_q + OUT_BITS'(sum >> FracW);
    signed_mag = ctl3_q.neg ? (OUT_BITS'(0) - mag) : mag;
  end

  // Output register; holds while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid4_q <= 1'b0;
    end else if (ready4) begin
      valid4_q <= ctl3_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready4 && ctl3_q.valid) begin
      sample_q <= signed_mag;
      last4_q  <= ctl3_q.last;
    end
  end

  assign valid_o  = valid4_q;
  assign last_o   = last4_q;
  assign sample_o = sample_q;

endmodule

`default_nettype wire

>>> sv/sine_oscillator_phase_accumulator_top.sv
// Channel   Direction  Accepted when                  Payload
// s_axis    in         s_axis_tvalid & s_axis_tready  tdata[0] restart, tlast block_last
// m_axis    out        m_axis_tvalid & m_axis_tready  tdata sample, tlast block_last_out
// cfg       in         cfg_we_i                       cfg_wdata_i phase_step
//
// One request per cycle while m_axis is not stalled; a taken request passes through the
// phase register, table read, partial products and output register in turn.
// Reset clears phase, phase step and all stage valid bits.
// Each stage holds while the next one is full; empty stages close up under a stall.
`default_nettype none

module sine_oscillator_phase_accumulator_top #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned OUT_BITS        = 16,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [31:0]                   cfg_wdata_i,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire  [7:0]                    s_axis_tdata,  // [0] restart
  input  wire                           s_axis_tlast,  // block_last
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  output logic [((OUT_BITS+7)/8)*8-1:0] m_axis_tdata,  // [OUT_BITS-1:0] sample
  output logic                          m_axis_tlast   // block_last_out
);

  localparam int unsigned TdataW = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned FracW  = PHASE_BITS - TABLE_ADDR_BITS - 1;

  logic [31:0]              step_q;
  logic [PHASE_BITS+31:0]   step_wide;
  logic [PHASE_BITS-1:0]    step_aligned;
  logic [PHASE_BITS-1:0]    phase_q;
  logic [PHASE_BITS-1:0]    phase_cur;
  logic [PHASE_BITS-1:0]    phase_s1_q;
  snco_pkg::snco_ctl_t      ctl1_q;
  logic                     accept;
  logic                     ready1;
  logic                     ready2;

  snco_pkg::snco_ctl_t      ctl2;
  logic [OUT_BITS-1:0]      lo;
  logic [OUT_BITS-1:0]      hi;
  logic [FracW-1:0]         frac;
  logic                     ready3;
  logic [OUT_BITS-1:0]      sample;

  // Phase step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cfg_we_i) begin
      step_q <= cfg_wdata_i;
    end
  end

  // Align the 32-bit tuning word to the accumulator width
  assign step_wide    = {step_q, PHASE_BITS'(0)};
  assign step_aligned = step_wide[PHASE_BITS+31:32];

  assign ready1        = !ctl1_q.valid || ready2;
  assign s_axis_tready = ready1;
  assign accept        = s_axis_tvalid && ready1;
  assign phase_cur     = s_axis_tdata[0] ? '0 : phase_q;

  // Advance the accumulator on each request; restart clears it first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      ctl1_q  <= '0;
    end else begin
      if (accept) begin
        phase_q <= phase_cur + step_aligned;
      end
      if (ready1) begin
        ctl1_q.valid <= s_axis_tvalid;
        ctl1_q.last  <= s_axis_tlast;
        ctl1_q.neg   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      phase_s1_q <= phase_cur;
    end
  end

  snco_lookup #(
    .PHASE_BITS      (PHASE_BITS),
    .OUT_BITS        (OUT_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_lookup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_ctl_i   (ctl1_q),
    .phase_i    (phase_s1_q),
    .up_ready_o (ready2),
    .dn_ready_i (ready3),
    .dn_ctl_o   (ctl2),
    .lo_o       (lo),
    .hi_o       (hi),
    .frac_o     (frac)
  );

  snco_interp #(
    .PHASE_BITS      (PHASE_BITS),
    .OUT_BITS        (OUT_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_interp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_ctl_i   (ctl2),
    .lo_i       (lo),
    .hi_i       (hi),
    .frac_i     (frac),
    .up_ready_o (ready3),
    .valid_o    (m_axis_tvalid),
    .last_o     (m_axis_tlast),
    .ready_i    (m_axis_tready),
    .sample_o   (sample)
  );

  assign m_axis_tdata = TdataW'(sample);

endmodule

`default_nettype wire
